[hdl/chh_pkg.sv]
// ----------------------------------------------------------------------------
// chh_pkg
// Types, constants and the arctangent table for the compass heading block.
// ----------------------------------------------------------------------------
package chh_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int STAGE_W       = $clog2(TABLE_LEN);

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 17;
    localparam int DELTA_W  = 18;
    localparam int DECL_W   = 15;
    localparam int HDG_W    = 15;
    localparam int XW       = 30;
    localparam int ZW       = 26;
    localparam int QW       = ZW - 8;
    localparam int ATAN_W   = 20;

    localparam int PADDR_W  = 3;
    localparam logic [PADDR_W-1:0] REG_DECLINATION_ADDR = 3'd0;

    localparam logic signed [SAMPLE_W-1:0] CAL_RESET_HIGH = -16'sd10000;
    localparam logic signed [SAMPLE_W-1:0] CAL_RESET_LOW  = 16'sd10000;

    localparam logic signed [ZW-1:0] Z_HALF_TURN = 26'sd2949120;
    localparam logic signed [ZW-1:0] Z_ROUND     = 26'sd128;
    localparam logic signed [QW-1:0] FULL_TURN   = 18'sd23040;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 56;

    typedef enum logic [1:0] {
        ACT_RESTART = 2'd0,
        ACT_CAL     = 2'd1,
        ACT_HEADING = 2'd2,
        ACT_NONE    = 2'd3
    } chh_action_t;

    typedef struct packed {
        logic                       hdg;
        logic signed [SAMPLE_W-1:0] xs;
        logic signed [SAMPLE_W-1:0] ys;
        logic signed [SUM_W-1:0]    xsum;
        logic signed [SUM_W-1:0]    ysum;
    } chh_cal_t;

    typedef struct packed {
        logic                    hdg;
        logic                    zero;
        logic signed [XW-1:0]    x;
        logic signed [XW-1:0]    y;
        logic signed [ZW-1:0]    z;
        logic signed [SUM_W-1:0] xsum;
        logic signed [SUM_W-1:0] ysum;
    } chh_vec_t;

    typedef struct packed {
        logic                    hdg;
        logic signed [ZW-1:0]    t;
        logic signed [SUM_W-1:0] xsum;
        logic signed [SUM_W-1:0] ysum;
    } chh_sum_t;

    typedef struct packed {
        logic [HDG_W-1:0]        heading;
        logic signed [SUM_W-1:0] xsum;
        logic signed [SUM_W-1:0] ysum;
    } chh_res_t;

    // round(atan(2^-i) * 16384 * 180 / pi)
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STAGE_W-1:0] i);
        logic [ATAN_W-1:0] a;
        case (i)
            5'd0:    a = 20'd737280;
            5'd1:    a = 20'd435242;
            5'd2:    a = 20'd229970;
            5'd3:    a = 20'd116736;
            5'd4:    a = 20'd58595;
            5'd5:    a = 20'd29326;
            5'd6:    a = 20'd14667;
            5'd7:    a = 20'd7334;
            5'd8:    a = 20'd3667;
            5'd9:    a = 20'd1833;
            5'd10:   a = 20'd917;
            5'd11:   a = 20'd458;
            5'd12:   a = 20'd229;
            5'd13:   a = 20'd115;
            5'd14:   a = 20'd57;
            5'd15:   a = 20'd29;
            5'd16:   a = 20'd14;
            5'd17:   a = 20'd7;
            5'd18:   a = 20'd4;
            5'd19:   a = 20'd2;
            5'd20:   a = 20'd1;
            default: a = 20'd0;
        endcase
        return a;
    endfunction

endpackage

[hdl/compass_heading_hard_iron.sv]
// ----------------------------------------------------------------------------
// compass_heading_hard_iron
// Magnetometer heading with hard-iron calibration and a CORDIC atan2 chain.
// ----------------------------------------------------------------------------
// Input stream: tuser = action (restart, calibration sample, heading sample),
// tdata = x_sample, y_sample. One result per input transfer, in order:
// heading in 1/64 degree (0 for non-heading actions) and both doubled centers
// as they stand after that transfer.
// Registered stages in order: calibration stage, centering stage, one cell per
// CORDIC rotation, declination add and wrap.
// One transfer per cycle unless the receiver stalls; every cell has its own register.
// A stalled receiver holds the output register; cells behind it keep filling
// empty slots and s_axis_tready drops once the chain is full.
// Reset clears min/max to +/-10000 and declination to 0, empties the chain.
// Declination sits at APB address 0; write it only while the chain is empty.
// ----------------------------------------------------------------------------
module compass_heading_hard_iron
    import chh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // x_sample, y_sample
    input  logic [1:0]             s_axis_tuser,  // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // heading_angle, x_center_doubled,
                                                  // y_center_doubled, zero pad
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic signed [DECL_W-1:0] decl_reg;

    logic     cal_valid, cal_ready;
    chh_cal_t cal_data;

    logic     vec_valid [0:CORDIC_STAGES];
    logic     vec_ready [0:CORDIC_STAGES];
    chh_vec_t vec_data  [0:CORDIC_STAGES];

    chh_res_t res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DECLINATION_ADDR)
                  ? {{(32-DECL_W){decl_reg[DECL_W-1]}}, decl_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_DECLINATION_ADDR))
        begin
            decl_reg <= pwdata[DECL_W-1:0];
        end
    end

    chh_calib u_calib (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tuser),
        .x_sample  (s_axis_tdata[SAMPLE_W-1:0]),
        .y_sample  (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .out_data  (cal_data)
    );

    chh_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cal_valid),
        .in_ready  (cal_ready),
        .in_data   (cal_data),
        .out_valid (vec_valid[0]),
        .out_ready (vec_ready[0]),
        .out_data  (vec_data[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        chh_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(g)),
            .in_valid  (vec_valid[g]),
            .in_ready  (vec_ready[g]),
            .in_data   (vec_data[g]),
            .out_valid (vec_valid[g+1]),
            .out_ready (vec_ready[g+1]),
            .out_data  (vec_data[g+1])
        );
    end

    chh_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .declination (decl_reg),
        .in_valid    (vec_valid[CORDIC_STAGES]),
        .in_ready    (vec_ready[CORDIC_STAGES]),
        .in_data     (vec_data[CORDIC_STAGES]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (res)
    );

    assign m_axis_tdata = {{(TDATA_OUT_W-HDG_W-2*SUM_W){1'b0}}, res.ysum, res.xsum, res.heading};

endmodule

[hdl/chh_calib.sv]
// ----------------------------------------------------------------------------
// chh_calib
// Hard-iron min/max tracking and doubled center sums, one registered stage.
// ----------------------------------------------------------------------------
module chh_calib
    import chh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 action,
    input  logic signed [SAMPLE_W-1:0] x_sample,
    input  logic signed [SAMPLE_W-1:0] y_sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output chh_cal_t                   out_data
);

    logic signed [SAMPLE_W-1:0] x_hi_reg, x_lo_reg, y_hi_reg, y_lo_reg;
    logic signed [SAMPLE_W-1:0] x_hi_next, x_lo_next, y_hi_next, y_lo_next;
    logic                       valid_reg;
    chh_cal_t                   data_reg, data_next;
    logic                       take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        x_hi_next = x_hi_reg;
        x_lo_next = x_lo_reg;
        y_hi_next = y_hi_reg;
        y_lo_next = y_lo_reg;
        if (take)
        begin
            case (chh_action_t'(action))
                ACT_RESTART:
                begin
                    x_hi_next = CAL_RESET_HIGH;
                    y_hi_next = CAL_RESET_HIGH;
                    x_lo_next = CAL_RESET_LOW;
                    y_lo_next = CAL_RESET_LOW;
                end
                ACT_CAL:
                begin
                    if (x_sample > x_hi_reg) x_hi_next = x_sample;
                    if (y_sample > y_hi_reg) y_hi_next = y_sample;
                    if (x_sample < x_lo_reg) x_lo_next = x_sample;
                    if (y_sample < y_lo_reg) y_lo_next = y_sample;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        data_next.hdg  = (chh_action_t'(action) == ACT_HEADING);
        data_next.xs   = x_sample;
        data_next.ys   = y_sample;
        data_next.xsum = SUM_W'(x_hi_next) + SUM_W'(x_lo_next);
        data_next.ysum = SUM_W'(y_hi_next) + SUM_W'(y_lo_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_hi_reg  <= CAL_RESET_HIGH;
            y_hi_reg  <= CAL_RESET_HIGH;
            x_lo_reg  <= CAL_RESET_LOW;
            y_lo_reg  <= CAL_RESET_LOW;
            valid_reg <= 1'b0;
        end
        else
        begin
            x_hi_reg <= x_hi_next;
            x_lo_reg <= x_lo_next;
            y_hi_reg <= y_hi_next;
            y_lo_reg <= y_lo_next;
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/chh_prep.sv]
// ----------------------------------------------------------------------------
// chh_prep
// Centers the sample, scales it and folds it into the right half plane.
// ----------------------------------------------------------------------------
module chh_prep
    import chh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  chh_cal_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output chh_vec_t out_data
);

    logic                      valid_reg;
    chh_vec_t                  data_reg, data_next;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [XW-1:0]      xi, yi;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign dx = {in_data.xs[SAMPLE_W-1], in_data.xs, 1'b0}
              - {in_data.xsum[SUM_W-1], in_data.xsum};
    assign dy = {in_data.ys[SAMPLE_W-1], in_data.ys, 1'b0}
              - {in_data.ysum[SUM_W-1], in_data.ysum};
    assign xi = {{(XW-DELTA_W-8){dx[DELTA_W-1]}}, dx, 8'd0};
    assign yi = {{(XW-DELTA_W-8){dy[DELTA_W-1]}}, dy, 8'd0};

    always_comb
    begin
        data_next.hdg  = in_data.hdg;
        data_next.zero = (dx == '0) && (dy == '0);
        data_next.xsum = in_data.xsum;
        data_next.ysum = in_data.ysum;
        if (dx[DELTA_W-1])
        begin
            data_next.x = -xi;
            data_next.y = -yi;
            data_next.z = Z_HALF_TURN;
        end
        else
        begin
            data_next.x = xi;
            data_next.y = yi;
            data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/chh_cordic_cell.sv]
// ----------------------------------------------------------------------------
// chh_cordic_cell
// One vectoring CORDIC rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module chh_cordic_cell
    import chh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [STAGE_W-1:0] stage,
    input  logic               in_valid,
    output logic               in_ready,
    input  chh_vec_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output chh_vec_t           out_data
);

    logic                 valid_reg;
    chh_vec_t             data_reg, data_next;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign xs  = in_data.x >>> stage;
    assign ys  = in_data.y >>> stage;
    assign ang = signed'({{(ZW-ATAN_W){1'b0}}, atan_entry(stage)});

    always_comb
    begin
        data_next = in_data;
        if (!in_data.y[XW-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + ang;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/chh_post.sv]
// ----------------------------------------------------------------------------
// chh_post
// Adds declination, rounds to 1/64 degree and wraps into one turn.
// Two registered stages; the second is the output register.
// ----------------------------------------------------------------------------
module chh_post
    import chh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DECL_W-1:0] declination,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  chh_vec_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output chh_res_t                 out_data
);

    logic                 sum_valid_reg, res_valid_reg;
    logic                 sum_ready;
    chh_sum_t             sum_reg, sum_next;
    chh_res_t             res_reg, res_next;
    logic signed [ZW-1:0] dterm, zsel;
    logic signed [QW-1:0] q, qw;

    assign sum_ready = !res_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    assign dterm = {{(ZW-DECL_W-8){declination[DECL_W-1]}}, declination, 8'd0};
    assign zsel  = in_data.zero ? '0 : in_data.z;

    always_comb
    begin
        sum_next.hdg  = in_data.hdg;
        sum_next.t    = zsel + dterm + Z_ROUND;
        sum_next.xsum = in_data.xsum;
        sum_next.ysum = in_data.ysum;
    end

    assign q = sum_reg.t[ZW-1:8];

    always_comb
    begin
        if (q[QW-1])
        begin
            qw = q + FULL_TURN;
        end
        else if (q >= FULL_TURN)
        begin
            qw = q - FULL_TURN;
        end
        else
        begin
            qw = q;
        end
        res_next.heading = sum_reg.hdg ? qw[HDG_W-1:0] : '0;
        res_next.xsum    = sum_reg.xsum;
        res_next.ysum    = sum_reg.ysum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                res_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg && sum_ready)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[hdl/chh_checker.sv]
// ----------------------------------------------------------------------------
// chh_checker
// Port-level checks for the compass heading block, bound to the top level.
// ----------------------------------------------------------------------------
module chh_checker
    import chh_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input logic                   pready
);

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[HDG_W-1:0] < 15'd23040))
        else $error("heading outside one turn");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_OUT_W-1:HDG_W+2*SUM_W] == '0))
        else $error("tdata pad bits set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_no_result_at_start: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result out of reset");

    a_pready_high: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind compass_heading_hard_iron chh_checker u_chh_checker (.*);

[verif/tb_compass_heading_hard_iron.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_compass_heading_hard_iron
// Self-checking bench for the compass heading block with hard-iron calibration.
// ----------------------------------------------------------------------------
// Samples are queued by the stimulus process and streamed in by a clocked
// driver. Each accepted input transfer updates an internal min/max tracker and
// CORDIC heading predictor. The expected result is queued, and a clocked
// monitor compares every output transfer with it. The run goes through several
// declination settings, with and without idle cycles on either side. Two phases
// include a long output stall; one of them also waits for a full drain midway.
// ----------------------------------------------------------------------------
module tb_compass_heading_hard_iron;
    import chh_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int PIPE_LAT       = CORDIC_STAGES + 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 190;
    localparam int ANGLE_FULL     = 23040;

    typedef struct packed {
        chh_action_t                act;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } sample_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // x_sample, y_sample
    logic [1:0]             s_axis_tuser = '0;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;        // heading_angle, x_center_doubled,
                                                 // y_center_doubled, zero pad
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    sample_t  sample_q[$];
    chh_res_t heading_exp_q[$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int fail_cnt = 0;

    // predictor state
    logic signed [DECL_W-1:0]   decl_setting;
    logic signed [SAMPLE_W-1:0] x_max, x_min, y_max, y_min;
    longint arctan_lut [0:23] = '{737280, 435242, 229970, 116736, 58595, 29326,
                                  14667, 7334, 3667, 1833, 917, 458, 229, 115,
                                  57, 29, 14, 7, 4, 2, 1, 0, 0, 0};

    compass_heading_hard_iron u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [HDG_W-1:0] cordic_heading(input longint dx, input longint dy);
        longint vx, vy, ang, sx, sy, tsum, q;
        int k;
        vx = dx * 256;
        vy = dy * 256;
        ang = 0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            ang = 180 * 16384;
        end
        for (k = 0; k < CORDIC_STAGES && k < 24; k++)
        begin
            sx = vx >>> k;
            sy = vy >>> k;
            if (vy >= 0)
            begin
                vx = vx + sy;
                vy = vy - sx;
                ang = ang + arctan_lut[k];
            end
            else
            begin
                vx = vx - sy;
                vy = vy + sx;
                ang = ang - arctan_lut[k];
            end
        end
        if (dx == 0 && dy == 0)
            ang = 0;
        tsum = ang + longint'(decl_setting) * 256;
        q = ((tsum + 128) >>> 8) % ANGLE_FULL;
        if (q < 0)
            q = q + ANGLE_FULL;
        return q[HDG_W-1:0];
    endfunction

    function automatic void cal_restart();
        x_max = CAL_RESET_HIGH;
        y_max = CAL_RESET_HIGH;
        x_min = CAL_RESET_LOW;
        y_min = CAL_RESET_LOW;
    endfunction

    function automatic chh_res_t predict_heading(input sample_t s);
        chh_res_t r;
        longint xs, ys;
        if (s.act == ACT_RESTART)
            cal_restart();
        else if (s.act == ACT_CAL)
        begin
            if (s.x > x_max) x_max = s.x;
            if (s.y > y_max) y_max = s.y;
            if (s.x < x_min) x_min = s.x;
            if (s.y < y_min) y_min = s.y;
        end
        xs = longint'(x_max) + longint'(x_min);
        ys = longint'(y_max) + longint'(y_min);
        r.heading = '0;
        if (s.act == ACT_HEADING)
            r.heading = cordic_heading(2 * longint'(s.x) - xs, 2 * longint'(s.y) - ys);
        r.xsum = xs[SUM_W-1:0];
        r.ysum = ys[SUM_W-1:0];
        return r;
    endfunction

    // input side: driver and acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                heading_exp_q.push_back(predict_heading(
                    '{chh_action_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16]}));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_axis_tuser  <= sample_q[0].act;
                    s_axis_tdata  <= {sample_q[0].y, sample_q[0].x};
                    s_axis_tvalid <= 1'b1;
                    void'(sample_q.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_done != hold_req)
        begin
            hold_done = hold_req;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // output side: compare
    always @(posedge clk)
    begin
        chh_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.heading = m_axis_tdata[14:0];
            got.xsum    = m_axis_tdata[31:15];
            got.ysum    = m_axis_tdata[48:32];
            if (heading_exp_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("ERROR: unexpected result heading=%0d xsum=%0d ysum=%0d",
                             got.heading, got.xsum, got.ysum);
            end
            else
            begin
                want = heading_exp_q.pop_front();
                if (got.heading !== want.heading || got.xsum !== want.xsum ||
                    got.ysum !== want.ysum)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"ERROR: heading exp %0d got %0d, ",
                                  "xsum exp %0d got %0d, ysum exp %0d got %0d"},
                                 want.heading, got.heading, want.xsum, got.xsum,
                                 want.ysum, got.ysum);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (sample_q.size() == 0 && heading_exp_q.size() == 0 && !s_axis_tvalid))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_sample(input chh_action_t act, input int x, input int y);
        sample_t s;
        s.act = act;
        s.x = x[15:0];
        s.y = y[15:0];
        sample_q.push_back(s);
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || heading_exp_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    task automatic write_declination(input logic signed [DECL_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_DECLINATION_ADDR;
        pwdata  <= {{(32-DECL_W){v[DECL_W-1]}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        decl_setting = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int near(input int c, input int r);
        return c + int'($urandom_range(2 * r)) - r;
    endfunction

    // mostly restart / calibrate / heading runs around a random center
    task automatic queue_random(input int n);
        int cnt, cx, cy, rad, ncal, nhdg, j;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(9) < 8)
            begin
                cx   = near(0, 8000);
                cy   = near(0, 8000);
                rad  = $urandom_range(20000, 1);
                ncal = $urandom_range(8, 1);
                nhdg = $urandom_range(12, 1);
                if ($urandom_range(3) != 0)
                begin
                    push_sample(ACT_RESTART, $urandom, $urandom);
                    cnt++;
                end
                for (j = 0; j < ncal; j++)
                begin
                    if ($urandom_range(4) == 0)
                        push_sample(ACT_CAL, $urandom, $urandom);
                    else
                        push_sample(ACT_CAL, near(cx, rad), near(cy, rad));
                end
                for (j = 0; j < nhdg; j++)
                begin
                    if ($urandom_range(4) == 0)
                        push_sample(ACT_HEADING, $urandom, $urandom);
                    else
                        push_sample(ACT_HEADING, near(cx, rad), near(cy, rad));
                end
                cnt = cnt + ncal + nhdg;
            end
            else
            begin
                push_sample(chh_action_t'($urandom_range(3)), $urandom, $urandom);
                cnt++;
            end
        end
    endtask

    // sample at the center if x and y lie within +/-10000: heading is then the declination alone
    task automatic queue_zero_vector(input int x, input int y);
        push_sample(ACT_RESTART, 0, 0);
        push_sample(ACT_CAL, x, y);
        push_sample(ACT_HEADING, x, y);
    endtask

    initial
    begin
        logic signed [DECL_W-1:0] decl_list [0:4];
        int p;
        decl_list = '{15'sd11520, -15'sd11520, 15'sd16383, -15'sd16384, 15'sd0};
        decl_setting = '0;
        cal_restart();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: uncalibrated, extremes, axes, zero vector, unused action
        push_sample(ACT_HEADING, 100, 0);
        push_sample(ACT_HEADING, 0, 0);
        push_sample(ACT_NONE, -1, -1);
        push_sample(ACT_CAL, 32767, -32768);
        push_sample(ACT_CAL, -32768, 32767);
        push_sample(ACT_HEADING, 32767, 32767);
        push_sample(ACT_HEADING, -32768, -32768);
        push_sample(ACT_HEADING, 0, 0);
        push_sample(ACT_HEADING, 32767, -1);
        push_sample(ACT_NONE, 12345, -12345);
        push_sample(ACT_RESTART, 32767, 32767);
        push_sample(ACT_HEADING, -32768, 32767);
        queue_zero_vector(100, 200);
        push_sample(ACT_HEADING, -50, 200);
        push_sample(ACT_HEADING, 300, 200);
        push_sample(ACT_HEADING, 100, 500);
        push_sample(ACT_HEADING, 100, -100);
        push_sample(ACT_HEADING, 5000, 199);
        push_sample(ACT_HEADING, -5000, 201);
        push_sample(ACT_HEADING, -5000, 199);
        queue_random(PHASE_ITEMS);
        wait_drained();

        for (p = 0; p < 5; p++)
        begin
            write_declination(decl_list[p]);
            case (p)
                0: begin src_idle_pct = 75; snk_stall_pct = 0;  end
                1: begin src_idle_pct = 0;  snk_stall_pct = 75; end
                2: begin src_idle_pct = 13; snk_stall_pct = 13; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            queue_zero_vector(-32768, 32767);
            if (p == 4)
            begin
                // fill the chain against a held receiver, then pause until drained
                hold_req = hold_req + 1;
                queue_random(PHASE_ITEMS / 2);
                wait_drained();
                queue_zero_vector(7, -7);
                queue_random(PHASE_ITEMS / 2);
            end
            else
            begin
                if (p == 1)
                    hold_req = hold_req + 1;
                queue_random(PHASE_ITEMS);
            end
            wait_drained();
        end

        repeat (PIPE_LAT + 8) @(posedge clk);
        if (fail_cnt == 0 && heading_exp_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hdl/chh_pkg.sv
hdl/chh_calib.sv
hdl/chh_prep.sv
hdl/chh_cordic_cell.sv
hdl/chh_post.sv
hdl/compass_heading_hard_iron.sv
hdl/chh_checker.sv
verif/tb_compass_heading_hard_iron.sv
